>>> rtl/core/hsvc_pkg.sv
package hsvc_pkg;

  // hue geometry in 1/16 degree
  localparam int unsigned HueSector = 960;
  // offset that maps (hue + 32768) onto the same residue as hue mod 5760
  localparam logic [16:0] HueWrapOffset = 17'd1792;
  // q1.8 unity
  localparam logic [8:0] QOne = 9'd256;
  // reciprocal of 15 in 2^-16 units, exact for the ranges used here
  localparam logic [12:0] RecipFifteen = 13'd4370;
  // reciprocal of 6 in 2^-8 units, exact for quotients up to 70
  localparam logic [5:0] RecipSix = 6'd43;
  localparam logic [7:0] ResetScale = 8'd200;

  // sector codes, 60 degrees each
  localparam logic [2:0] SectorRedGreen  = 3'd0;
  localparam logic [2:0] SectorGreenRed  = 3'd1;
  localparam logic [2:0] SectorGreenBlue = 3'd2;
  localparam logic [2:0] SectorBlueGreen = 3'd3;
  localparam logic [2:0] SectorBlueRed   = 3'd4;

  // chroma, ramp position and offset of one pixel
  typedef struct packed {
    logic [2:0]  sector;
    logic [9:0]  rem;
    logic [16:0] chroma;
    logic [16:0] offset;
  } hsvc_chroma_t;

  // per-channel sums in units of 1 / (65536 * 960)
  typedef struct packed {
    logic [25:0] red;
    logic [25:0] green;
    logic [25:0] blue;
  } hsvc_sums_t;

endpackage

>>> rtl/core/hsvc_sector.sv
module hsvc_sector (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic signed [15:0]    hue,
  input  logic signed [9:0]     saturation,
  input  logic signed [9:0]     brightness,
  output logic                  out_valid,
  output hsvc_pkg::hsvc_chroma_t out_data
);

  // stage 1 registers
  logic        s1_valid_r;
  logic [16:0] s1_t_r;
  logic [8:0]  s1_sat_r;
  logic [8:0]  s1_val_r;
  // stage 2 registers
  logic        s2_valid_r;
  logic [16:0] s2_t_r;
  logic [6:0]  s2_q_r;
  logic [16:0] s2_chroma_r;
  logic [8:0]  s2_val_r;
  // stage 3 registers
  logic                  s3_valid_r;
  hsvc_pkg::hsvc_chroma_t s3_data_r;

  logic [16:0] t_nxt;
  logic [8:0]  sat_nxt;
  logic [8:0]  val_nxt;
  logic [23:0] q_prod;
  logic [17:0] chroma_prod;
  logic [11:0] six_prod;
  logic [3:0]  six_quot;
  logic [6:0]  sector_full;
  logic [16:0] sector_base;
  logic [16:0] rem_full;
  logic [16:0] offset_nxt;

  // hue offset into a positive range with the same residue mod 5760
  assign t_nxt = {1'b0, ~hue[15], hue[14:0]} + hsvc_pkg::HueWrapOffset;

  // clamp q1.8 inputs into 0..256
  always_comb begin
    if (saturation[9]) begin
      sat_nxt = '0;
    end else if (saturation > $signed(10'd256)) begin
      sat_nxt = hsvc_pkg::QOne;
    end else begin
      sat_nxt = saturation[8:0];
    end
    if (brightness[9]) begin
      val_nxt = '0;
    end else if (brightness > $signed(10'd256)) begin
      val_nxt = hsvc_pkg::QOne;
    end else begin
      val_nxt = brightness[8:0];
    end
  end

  // t / 960 as (t / 64) / 15 by reciprocal, chroma product
  assign q_prod      = 24'(s1_t_r[16:6]) * 24'(hsvc_pkg::RecipFifteen);
  assign chroma_prod = 18'(s1_val_r) * 18'(s1_sat_r);

  // sector = q mod 6, remainder within the sector, offset m
  assign six_prod    = 12'(s2_q_r) * 12'(hsvc_pkg::RecipSix);
  assign six_quot    = six_prod[11:8];
  assign sector_full = s2_q_r - 7'(six_quot * 4'd6);
  assign sector_base = 17'(s2_q_r) * 17'(hsvc_pkg::HueSector);
  assign rem_full    = s2_t_r - sector_base;
  assign offset_nxt  = {s2_val_r, 8'b0} - s2_chroma_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_t_r             <= t_nxt;
      s1_sat_r           <= sat_nxt;
      s1_val_r           <= val_nxt;
      s2_t_r             <= s1_t_r;
      s2_q_r             <= q_prod[22:16];
      s2_chroma_r        <= chroma_prod[16:0];
      s2_val_r           <= s1_val_r;
      s3_data_r.sector   <= sector_full[2:0];
      s3_data_r.rem      <= rem_full[9:0];
      s3_data_r.chroma   <= s2_chroma_r;
      s3_data_r.offset   <= offset_nxt;
    end
  end

  assign out_valid = s3_valid_r;
  assign out_data  = s3_data_r;

endmodule

>>> rtl/core/hsvc_mix.sv
module hsvc_mix (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  hsvc_pkg::hsvc_chroma_t in_data,
  output logic                   out_valid,
  output hsvc_pkg::hsvc_sums_t   out_data
);

  // stage 4 registers
  logic        s4_valid_r;
  logic [2:0]  s4_sector_r;
  logic [25:0] s4_full_r;
  logic [25:0] s4_ramp_r;
  logic [25:0] s4_offset_r;
  // stage 5 registers
  logic                 s5_valid_r;
  hsvc_pkg::hsvc_sums_t s5_data_r;

  logic [9:0]  ramp_mul;
  logic [26:0] full_prod;
  logic [26:0] ramp_prod;
  logic [26:0] offset_prod;
  logic [25:0] red_sel;
  logic [25:0] green_sel;
  logic [25:0] blue_sel;

  // rising ramp in even sectors, falling in odd ones
  assign ramp_mul    = in_data.sector[0] ? 10'(hsvc_pkg::HueSector) - in_data.rem
                                         : in_data.rem;
  assign full_prod   = 27'(in_data.chroma) * 27'(hsvc_pkg::HueSector);
  assign ramp_prod   = 27'(in_data.chroma) * 27'(ramp_mul);
  assign offset_prod = 27'(in_data.offset) * 27'(hsvc_pkg::HueSector);

  // sector table places chroma and ramp on the channels
  always_comb begin
    case (s4_sector_r)
      hsvc_pkg::SectorRedGreen: begin
        red_sel = s4_full_r; green_sel = s4_ramp_r; blue_sel = '0;
      end
      hsvc_pkg::SectorGreenRed: begin
        red_sel = s4_ramp_r; green_sel = s4_full_r; blue_sel = '0;
      end
      hsvc_pkg::SectorGreenBlue: begin
        red_sel = '0; green_sel = s4_full_r; blue_sel = s4_ramp_r;
      end
      hsvc_pkg::SectorBlueGreen: begin
        red_sel = '0; green_sel = s4_ramp_r; blue_sel = s4_full_r;
      end
      hsvc_pkg::SectorBlueRed: begin
        red_sel = s4_ramp_r; green_sel = '0; blue_sel = s4_full_r;
      end
      default: begin
        red_sel = s4_full_r; green_sel = '0; blue_sel = s4_ramp_r;
      end
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else if (en) begin
      s4_valid_r <= in_valid;
      s5_valid_r <= s4_valid_r;
    end
  end

  // payload, sums never exceed 65536 * 960
  always_ff @(posedge clk) begin
    if (en) begin
      s4_sector_r     <= in_data.sector;
      s4_full_r       <= full_prod[25:0];
      s4_ramp_r       <= ramp_prod[25:0];
      s4_offset_r     <= offset_prod[25:0];
      s5_data_r.red   <= red_sel + s4_offset_r;
      s5_data_r.green <= green_sel + s4_offset_r;
      s5_data_r.blue  <= blue_sel + s4_offset_r;
    end
  end

  assign out_valid = s5_valid_r;
  assign out_data  = s5_data_r;

endmodule

>>> rtl/core/hsvc_scale.sv
module hsvc_scale (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic [7:0]           scale,
  input  logic                 in_valid,
  input  hsvc_pkg::hsvc_sums_t in_data,
  output logic                 out_valid,
  output logic [7:0]           red,
  output logic [7:0]           green,
  output logic [7:0]           blue
);

  // stage 6 registers, products already divided by 65536
  logic        s6_valid_r;
  logic [17:0] s6_red_r;
  logic [17:0] s6_green_r;
  logic [17:0] s6_blue_r;
  // stage 7 output registers
  logic        s7_valid_r;
  logic [7:0]  s7_red_r;
  logic [7:0]  s7_green_r;
  logic [7:0]  s7_blue_r;

  logic [33:0] red_prod;
  logic [33:0] green_prod;
  logic [33:0] blue_prod;
  logic [23:0] red_quot;
  logic [23:0] green_quot;
  logic [23:0] blue_quot;

  // channel times output scale
  assign red_prod   = 34'(in_data.red) * 34'(scale);
  assign green_prod = 34'(in_data.green) * 34'(scale);
  assign blue_prod  = 34'(in_data.blue) * 34'(scale);

  // divide by 960 as (x / 64) / 15 by reciprocal
  assign red_quot   = 24'(s6_red_r[17:6]) * 24'(hsvc_pkg::RecipFifteen);
  assign green_quot = 24'(s6_green_r[17:6]) * 24'(hsvc_pkg::RecipFifteen);
  assign blue_quot  = 24'(s6_blue_r[17:6]) * 24'(hsvc_pkg::RecipFifteen);

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r <= 1'b0;
      s7_valid_r <= 1'b0;
    end else if (en) begin
      s6_valid_r <= in_valid;
      s7_valid_r <= s6_valid_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      s6_red_r   <= red_prod[33:16];
      s6_green_r <= green_prod[33:16];
      s6_blue_r  <= blue_prod[33:16];
      s7_red_r   <= red_quot[23:16];
      s7_green_r <= green_quot[23:16];
      s7_blue_r  <= blue_quot[23:16];
    end
  end

  assign out_valid = s7_valid_r;
  assign red       = s7_red_r;
  assign green     = s7_green_r;
  assign blue      = s7_blue_r;

endmodule

>>> rtl/core/hsv_to_rgb_converter_unit.sv
// channel  direction  ports                          payload
// in       slave      in_tvalid/in_tready/in_tdata   hue, saturation, brightness
// out      master     out_tvalid/out_tready/out_tdata  red, green, blue
// cfg      slave      cfg_valid/cfg_ready/cfg_data   output_scale
//
// seven register stages, one pixel per clock while the output is not stalled
// the last stage is the output register; depth is set by the multiplier chain
// reset clears all valid bits and loads output_scale with 200
// a stalled output holds the whole pipeline in place; nothing is dropped
module hsv_to_rgb_converter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // hue[15:0], saturation[25:16], brightness[35:26], zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // red[7:0], green[15:8], blue[23:16]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // output_scale
);

  logic                   en;
  logic [7:0]             scale_r;
  logic                   sec_valid;
  hsvc_pkg::hsvc_chroma_t sec_data;
  logic                   mix_valid;
  hsvc_pkg::hsvc_sums_t   mix_data;
  logic [7:0]             red;
  logic [7:0]             green;
  logic [7:0]             blue;

  // pipeline advances unless the output holds an untaken transfer
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  // output scale register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= hsvc_pkg::ResetScale;
    end else if (cfg_valid) begin
      scale_r <= cfg_data;
    end
  end

  // hue wrap, clamp, chroma
  hsvc_sector u_sector (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_tvalid),
    .hue        ($signed(in_tdata[15:0])),
    .saturation ($signed(in_tdata[25:16])),
    .brightness ($signed(in_tdata[35:26])),
    .out_valid  (sec_valid),
    .out_data   (sec_data)
  );

  // ramp and channel sums
  hsvc_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sec_valid),
    .in_data   (sec_data),
    .out_valid (mix_valid),
    .out_data  (mix_data)
  );

  // scale and divide
  hsvc_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .scale     (scale_r),
    .in_valid  (mix_valid),
    .in_data   (mix_data),
    .out_valid (out_tvalid),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  assign out_tdata = {blue, green, red};

endmodule

>>> verif/hsv_to_rgb_checker.sv
module hsv_to_rgb_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // hue[15:0], saturation[25:16], brightness[35:26], zero
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // red[7:0], green[15:8], blue[23:16]
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,   // output_scale
  output int          fail_count,
  output int          pending_count,
  output int          pixel_count,
  output int          scale_count
);

  localparam int SectorLen = int'(hsvc_pkg::HueSector);
  localparam int HueTurn = 6 * SectorLen;
  // channel sums are in units of 1 / (65536 * 960)
  localparam longint unsigned FullScaleDen = 64'd65536 * 64'(hsvc_pkg::HueSector);

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_pixel_t;

  typedef struct packed {
    logic [15:0] hue;
    logic [9:0]  sat;
    logic [9:0]  bri;
    rgb_pixel_t  rgb;
  } pixel_job_t;

  pixel_job_t rgb_expected_q[$];
  pixel_job_t job;
  rgb_pixel_t got;
  logic [7:0] output_scale;

  initial begin
    fail_count = 0;
    pending_count = 0;
    pixel_count = 0;
    scale_count = 0;
    output_scale = hsvc_pkg::ResetScale;
  end

  // q1.8 clamp to 0 .. 1.0
  function automatic longint unsigned clamp_unit(logic signed [9:0] q);
    if (int'(q) < 0) return 0;
    if (int'(q) > int'(hsvc_pkg::QOne)) return longint'(hsvc_pkg::QOne);
    return longint'(int'(q));
  endfunction

  function automatic logic [7:0] scaled_channel(longint unsigned sum, logic [7:0] scale);
    return 8'((sum * scale) / FullScaleDen);
  endfunction

  // exact fixed-point hsv to rgb, no intermediate rounding
  function automatic rgb_pixel_t hsv_pixel_to_rgb(logic [15:0] hue_bits, logic [9:0] sat_bits,
                                                  logic [9:0] bri_bits, logic [7:0] scale);
    int wrapped;
    logic [2:0] sector;
    longint unsigned ramp_pos, s_q, v_q, chroma, full_c, ramp, offs, r_sum, g_sum, b_sum;
    rgb_pixel_t px;
    // true modulo, negative hue wraps upward
    wrapped = int'($signed(hue_bits)) % HueTurn;
    if (wrapped < 0) wrapped += HueTurn;
    sector = 3'(wrapped / SectorLen);
    ramp_pos = longint'(wrapped % SectorLen);
    s_q = clamp_unit(sat_bits);
    v_q = clamp_unit(bri_bits);
    chroma = v_q * s_q;
    full_c = chroma * longint'(SectorLen);
    // ramp rises in even sectors and falls in odd ones
    ramp = sector[0] ? chroma * (longint'(SectorLen) - ramp_pos) : chroma * ramp_pos;
    offs = (v_q * longint'(hsvc_pkg::QOne) - chroma) * longint'(SectorLen);
    case (sector)
      hsvc_pkg::SectorRedGreen: begin
        r_sum = full_c; g_sum = ramp; b_sum = 0;
      end
      hsvc_pkg::SectorGreenRed: begin
        r_sum = ramp; g_sum = full_c; b_sum = 0;
      end
      hsvc_pkg::SectorGreenBlue: begin
        r_sum = 0; g_sum = full_c; b_sum = ramp;
      end
      hsvc_pkg::SectorBlueGreen: begin
        r_sum = 0; g_sum = ramp; b_sum = full_c;
      end
      hsvc_pkg::SectorBlueRed: begin
        r_sum = ramp; g_sum = 0; b_sum = full_c;
      end
      default: begin
        r_sum = full_c; g_sum = 0; b_sum = ramp;
      end
    endcase
    px.red = scaled_channel(r_sum + offs, scale);
    px.green = scaled_channel(g_sum + offs, scale);
    px.blue = scaled_channel(b_sum + offs, scale);
    return px;
  endfunction

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // watch all three channels
  always @(posedge clk) begin
    if (!rst_n) begin
      output_scale = hsvc_pkg::ResetScale;
      rgb_expected_q.delete();
      pending_count = 0;
    end else begin
      // expected color for every accepted pixel
      if (in_tvalid && in_tready) begin
        job.hue = in_tdata[15:0];
        job.sat = in_tdata[25:16];
        job.bri = in_tdata[35:26];
        job.rgb = hsv_pixel_to_rgb(job.hue, job.sat, job.bri, output_scale);
        rgb_expected_q.push_back(job);
      end
      // scale register write
      if (cfg_valid && cfg_ready) begin
        output_scale = cfg_data;
        scale_count++;
      end
      // compare each result transfer with the oldest expectation
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (rgb_expected_q.size() == 0) begin
          note_failure($sformatf("unexpected result r=%0d g=%0d b=%0d",
                                 got.red, got.green, got.blue));
        end else begin
          job = rgb_expected_q.pop_front();
          pixel_count++;
          if (got.red !== job.rgb.red || got.green !== job.rgb.green ||
              got.blue !== job.rgb.blue) begin
            note_failure($sformatf(
              "hue=%0d sat=%0d val=%0d scale=%0d exp r/g/b=%0d/%0d/%0d got %0d/%0d/%0d",
              $signed(job.hue), $signed(job.sat), $signed(job.bri), output_scale,
              job.rgb.red, job.rgb.green, job.rgb.blue, got.red, got.green, got.blue));
          end
        end
      end
      pending_count = rgb_expected_q.size();
    end
  end

endmodule

>>> verif/tb_hsv_to_rgb_converter_unit.sv
module tb_hsv_to_rgb_converter_unit;

  localparam int PhaseCount = 10;
  localparam int PhaseItems = 165;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // hue[15:0], saturation[25:16], brightness[35:26], zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // red[7:0], green[15:8], blue[23:16]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;   // output_scale

  int fail_count, pending_count, pixel_count, scale_count;
  bit gaps_on = 1'b1;
  int stall_left = 0;

  always #5 clk = ~clk;

  hsv_to_rgb_converter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  hsv_to_rgb_checker rgb_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .pixel_count   (pixel_count),
    .scale_count   (scale_count)
  );

  // result side back-pressure in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // valid stays high across back-to-back pixels, dropped only for a gap
  task automatic send_pixel(input int hue, input int sat, input int bri);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, 10'(bri), 10'(sat), 16'(hue)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // mostly in-range q1.8, with the limits and raw out-of-range values mixed in
  function automatic int pick_q18();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return $urandom_range(0, 256);
    if (roll == 6) return 0;
    if (roll == 7) return 256;
    return int'($urandom_range(0, 1023)) - 512;
  endfunction

  task automatic send_random_pixel();
    int roll, hue;
    roll = $urandom_range(0, 9);
    if (roll < 6) hue = $urandom_range(0, 5759);
    else if (roll < 8) hue = int'($urandom_range(0, 6)) * 960 + int'($urandom_range(0, 4)) - 2;
    else hue = int'($urandom_range(0, 65535)) - 32768;
    send_pixel(hue, pick_q18(), pick_q18());
  endtask

  // stop sending and wait until every pixel in flight has come out
  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic write_scale(input logic [7:0] scale);
    cfg_valid <= 1'b1;
    cfg_data <= scale;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] scale;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pixels at the reset scale: sector edges, wrap, clamps
    send_pixel(0, 256, 256);
    send_pixel(959, 256, 256);
    send_pixel(960, 256, 256);
    send_pixel(1919, 256, 256);
    send_pixel(1920, 256, 256);
    send_pixel(2880, 256, 256);
    send_pixel(3840, 256, 256);
    send_pixel(4800, 256, 256);
    send_pixel(5759, 256, 256);
    send_pixel(5760, 256, 256);
    send_pixel(-1, 256, 256);
    send_pixel(-5760, 200, 180);
    send_pixel(-32768, 128, 256);
    send_pixel(32767, 256, 128);
    send_pixel(480, 0, 256);
    send_pixel(1500, -512, 256);
    send_pixel(2400, -1, 200);
    send_pixel(3300, 257, 256);
    send_pixel(4200, 511, 511);
    send_pixel(5000, 256, 0);
    send_pixel(700, 256, -512);
    send_pixel(-700, 100, 257);
    send_pixel(-32768, -512, -512);
    send_pixel(32767, 511, -1);

    // random phases, each at its own scale; the last one runs without gaps
    for (int p = 0; p < PhaseCount; p++) begin
      drain_pipeline();
      case (p)
        0: scale = 8'd255;
        1: scale = 8'd0;
        2: scale = 8'd1;
        3: scale = 8'd128;
        default: scale = 8'($urandom_range(0, 255));
      endcase
      write_scale(scale);
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == PhaseCount - 1) gaps_on = 1'b0;
        else if (i % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
        send_random_pixel();
      end
    end

    drain_pipeline();
    repeat (20) @(posedge clk);
    $display("summary: %0d pixels checked over %0d scale writes plus the reset scale",
             pixel_count, scale_count);
    $display("summary: all six hue sectors, hue wrap, clamped saturation and value, zero scale");
    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
